// ===== design/pna_pkg.sv =====
// Port number allocator package: sizes, opcodes, status codes and the
// command/status structs between controller and datapath. No dependencies.
package pna_pkg;

   localparam int PORT_COUNT = 65536;
   localparam int OWNER_BITS = 16;

   localparam int FIELD_W    = 16;
   localparam int WORD_W     = 64;
   localparam int BIT_IDX_W  = 6;
   localparam int WORD_COUNT = (PORT_COUNT + WORD_W - 1) / WORD_W;
   localparam int SUM_COUNT  = (WORD_COUNT + WORD_W - 1) / WORD_W;
   localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int SIDX_W     = (SUM_COUNT > 1) ? $clog2(SUM_COUNT) : 1;
   localparam int PIDX_W     = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int CNT_W      = WIDX_W + 1;

   localparam int PORT_REM = PORT_COUNT % WORD_W;
   localparam int WORD_REM = WORD_COUNT % WORD_W;
   localparam logic [WORD_W-1:0] LAST_PAD =
      (PORT_REM == 0) ? '0 : ~((64'd1 << PORT_REM) - 64'd1);
   localparam logic [WORD_W-1:0] SUM_PAD =
      (WORD_REM == 0) ? '0 : ~((64'd1 << WORD_REM) - 64'd1);

   localparam logic [1:0] OP_CLAIM_NAMED = 2'd0;
   localparam logic [1:0] OP_CLAIM_ANY   = 2'd1;
   localparam logic [1:0] OP_RELEASE     = 2'd2;
   localparam logic [1:0] OP_LOOKUP      = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BUSY      = 2'd1;
   localparam logic [1:0] ST_NONE_FREE = 2'd2;
   localparam logic [1:0] ST_NOT_HELD  = 2'd3;

   typedef struct packed {
      logic clr_step;
      logic accept;
      logic sum_step;
      logic eval;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_any;
   } dp_status_type;

endpackage

// ===== design/pna_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pna_ctrl.sv =====
// Port number allocator controller: clearing pass, then sequences one item
// at a time through summary read, bitmap read and update. Uses pna_pkg.
module pna_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output pna_pkg::ctrl_cmd_type  cmd,
   input  pna_pkg::dp_status_type status
);
   import pna_pkg::*;

   localparam logic [1:0] S_CLR  = 2'd0;
   localparam logic [1:0] S_IDLE = 2'd1;
   localparam logic [1:0] S_SUM  = 2'd2;
   localparam logic [1:0] S_EVAL = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = status.req_any ? S_SUM : S_EVAL;
            end
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            state_in     = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== design/pna_datapath.sv =====
// Port number allocator datapath: in-use bitmap, full-word summary, top
// flags, owner store and result register. Uses pna_pkg and pna_ram.
module pna_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  pna_pkg::ctrl_cmd_type  cmd,
   output pna_pkg::dp_status_type status,
   input  logic [1:0]             req_opcode,
   input  logic [15:0]            req_port,
   input  logic [15:0]            req_owner,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [15:0]            rsp_port,
   output logic [15:0]            rsp_owner
);
   import pna_pkg::*;

   function automatic logic [BIT_IDX_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) begin
            idx = BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

   logic [1:0]            op_ff;
   logic [FIELD_W-1:0]    port_ff;
   logic [OWNER_BITS-1:0] owner_ff;
   logic [SIDX_W-1:0]     sidx_ff;
   logic [WIDX_W-1:0]     widx_ff;
   logic                  nofree_ff;
   logic [WIDX_W-1:0]     clr_cnt_ff;
   logic [SUM_COUNT-1:0]  top_ff;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [15:0]           rsp_port_ff;
   logic [15:0]           rsp_owner_ff;

   logic                  bm_wr_en, bm_rd_en;
   logic [WIDX_W-1:0]     bm_wr_addr, bm_rd_addr;
   logic [WORD_W-1:0]     bm_wr_data, bm_rd_data;
   logic                  sum_wr_en;
   logic [SIDX_W-1:0]     sum_wr_addr, sum_rd_addr;
   logic [WORD_W-1:0]     sum_wr_data, sum_rd_data;
   logic                  own_wr_en;
   logic [PIDX_W-1:0]     own_wr_addr;
   logic [OWNER_BITS-1:0] own_rd_data;

   logic [WORD_W-1:0]     top_word;
   logic [SIDX_W-1:0]     top_free_idx;
   logic                  top_all_full;
   logic [WIDX_W-1:0]     named_widx, any_widx;
   logic [SIDX_W-1:0]     named_sidx;
   logic                  is_any;
   logic [BIT_IDX_W-1:0]  bit_sel, sum_bit;
   logic [FIELD_W-1:0]    tgt_port;
   logic                  used, in_range, do_claim, do_release, do_change;
   logic [WORD_W-1:0]     bit_mask, new_word, new_sum;
   logic [1:0]            status_in;
   logic [15:0]           port_out_in, owner_out_in;

   // request decode and lowest-free search over the top flags
   assign top_word     = ~WORD_W'(~top_ff);
   assign top_free_idx = SIDX_W'(lowest_zero(top_word));
   assign top_all_full = &top_ff;
   assign named_widx   = WIDX_W'(req_port >> BIT_IDX_W);
   assign named_sidx   = SIDX_W'(req_port >> (2 * BIT_IDX_W));
   assign any_widx     = WIDX_W'({sidx_ff, lowest_zero(sum_rd_data)});

   assign status.req_any  = (req_opcode == OP_CLAIM_ANY);
   assign status.clr_last = (clr_cnt_ff == WIDX_W'(WORD_COUNT - 1));

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_opcode;
         port_ff   <= req_port;
         owner_ff  <= OWNER_BITS'(req_owner);
         sidx_ff   <= status.req_any ? top_free_idx : named_sidx;
         widx_ff   <= named_widx;
         nofree_ff <= top_all_full;
      end else if (cmd.sum_step) begin
         widx_ff   <= any_widx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= clr_cnt_ff + WIDX_W'(1);
      end
   end

   // evaluation: both words held in the RAM output registers
   assign is_any     = (op_ff == OP_CLAIM_ANY);
   assign bit_sel    = is_any ? lowest_zero(bm_rd_data) : port_ff[BIT_IDX_W-1:0];
   assign tgt_port   = is_any ? FIELD_W'({widx_ff, bit_sel}) : port_ff;
   assign used       = bm_rd_data[bit_sel];
   assign in_range   = ({1'b0, port_ff} < 17'(PORT_COUNT));
   assign do_claim   = ((op_ff == OP_CLAIM_NAMED) && in_range && !used)
                       || (is_any && !nofree_ff);
   assign do_release = (op_ff == OP_RELEASE) && in_range && used;
   assign do_change  = cmd.eval && (do_claim || do_release);
   assign bit_mask   = WORD_W'(1) << bit_sel;
   assign new_word   = do_claim ? (bm_rd_data | bit_mask) : (bm_rd_data & ~bit_mask);
   assign sum_bit    = BIT_IDX_W'(widx_ff);
   always_comb begin
      new_sum          = sum_rd_data;
      new_sum[sum_bit] = &new_word;
   end

   always_comb begin
      status_in    = ST_OK;
      port_out_in  = port_ff;
      owner_out_in = '0;
      unique case (op_ff)
         OP_CLAIM_NAMED: begin
            if (!(in_range && !used)) begin
               status_in = ST_BUSY;
            end
         end
         OP_CLAIM_ANY: begin
            if (nofree_ff) begin
               status_in   = ST_NONE_FREE;
               port_out_in = '0;
            end else begin
               port_out_in = tgt_port;
            end
         end
         OP_RELEASE: begin
            if (!(in_range && used)) begin
               status_in = ST_NOT_HELD;
            end
         end
         OP_LOOKUP: begin
            if (in_range && used) begin
               owner_out_in = 16'(own_rd_data);
            end else begin
               status_in = ST_NOT_HELD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.eval;
         if (do_change) begin
            top_ff[sidx_ff] <= &new_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         rsp_status_ff <= status_in;
         rsp_port_ff   <= port_out_in;
         rsp_owner_ff  <= owner_out_in;
      end
   end

   // memory ports
   assign bm_rd_en    = cmd.accept || cmd.sum_step;
   assign bm_rd_addr  = cmd.accept ? named_widx : any_widx;
   assign bm_wr_en    = cmd.clr_step || do_change;
   assign bm_wr_addr  = cmd.clr_step ? clr_cnt_ff : widx_ff;
   assign bm_wr_data  = cmd.clr_step ? (status.clr_last ? LAST_PAD : '0) : new_word;

   assign sum_rd_addr = status.req_any ? top_free_idx : named_sidx;
   assign sum_wr_en   = (cmd.clr_step && (CNT_W'(clr_cnt_ff) < CNT_W'(SUM_COUNT)))
                        || do_change;
   assign sum_wr_addr = cmd.clr_step ? SIDX_W'(clr_cnt_ff) : sidx_ff;
   assign sum_wr_data = cmd.clr_step
                        ? ((CNT_W'(clr_cnt_ff) == CNT_W'(SUM_COUNT - 1)) ? SUM_PAD : '0)
                        : new_sum;

   assign own_wr_en   = cmd.eval && do_claim;
   assign own_wr_addr = PIDX_W'(tgt_port);

   pna_ram #(.WIDTH(WORD_W), .DEPTH(WORD_COUNT)) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data),
      .rd_en   (bm_rd_en),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   pna_ram #(.WIDTH(WORD_W), .DEPTH(SUM_COUNT)) u_summary (
      .clock   (clock),
      .wr_en   (sum_wr_en),
      .wr_addr (sum_wr_addr),
      .wr_data (sum_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (sum_rd_addr),
      .rd_data (sum_rd_data)
   );

   pna_ram #(.WIDTH(OWNER_BITS), .DEPTH(PORT_COUNT)) u_owner (
      .clock   (clock),
      .wr_en   (own_wr_en),
      .wr_addr (own_wr_addr),
      .wr_data (owner_ff),
      .rd_en   (cmd.accept),
      .rd_addr (PIDX_W'(req_port)),
      .rd_data (own_rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_port   = rsp_port_ff;
   assign rsp_owner  = rsp_owner_ff;

endmodule

// ===== design/port_number_allocator.sv =====
// Port number allocator top level: controller plus datapath.
// Uses pna_pkg, pna_ctrl and pna_datapath.
//
// Item flow: an item is taken when start is high and busy is low; its single
// result appears on the rsp_ ports for one cycle with rsp_valid high and the
// receiver cannot hold it off. After reset the in-use bitmap is swept clear,
// one 64-port word a cycle, and busy stays high until the sweep is done.
// Claim-named, release and lookup go on straight to evaluation; claim-any
// takes a summary step first, since the summary and bitmap memory reads are
// registered and claim-any walks them in turn to find the lowest free port.
// The result is on the rsp_ ports in the first cycle that busy is low again,
// when the next item may already be taken. One item is in flight at a time.
module port_number_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_port,
   input  logic [15:0] req_owner,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_port,
   output logic [15:0] rsp_owner
);
   import pna_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   pna_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (dp_status)
   );

   pna_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (dp_status),
      .req_opcode (req_opcode),
      .req_port   (req_port),
      .req_owner  (req_owner),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_port   (rsp_port),
      .rsp_owner  (rsp_owner)
   );

endmodule
